### rtl/approximate_bitap_matcher_top_macros.svh
// ----------------------------------------------------------------------------
// Approximate bitap matcher assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef APPROXIMATE_BITAP_MATCHER_TOP_MACROS_SVH
`define APPROXIMATE_BITAP_MATCHER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ABM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("abm assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ABM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("abm assertion failed");

`endif

### rtl/abm_pkg.sv
// ----------------------------------------------------------------------------
// abm_pkg
// Shared constants, payload types and register codes of the bitap matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abm_pkg;

    localparam int PATTERN_MAX   = 32;
    localparam int ERRORS_MAX    = 4;
    localparam int PATTERN_WORDS = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int LEN_W         = 6;
    localparam int ERR_W         = 3;
    localparam int CNT_W         = 16;
    localparam int CHAR_W        = 8;
    localparam int LEN_IDX_W     = $clog2(PATTERN_MAX) > 0 ? $clog2(PATTERN_MAX) : 1;

    typedef logic [PATTERN_MAX-1:0]             t_vec;
    typedef t_vec [ERRORS_MAX:0]                t_vec_bank;
    typedef logic [PATTERN_MAX-1:0][CHAR_W-1:0] t_pat_bytes;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_0  = 3'd0,
        CFG_PATTERN_1  = 3'd1,
        CFG_PATTERN_2  = 3'd2,
        CFG_PATTERN_3  = 3'd3,
        CFG_LENGTH     = 3'd4,
        CFG_MAX_ERRORS = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              line_start;
    } t_in_item;

    typedef struct packed {
        logic             match_end;
        logic [CNT_W-1:0] line_matches;
    } t_out_item;

endpackage

### rtl/abm_char_mask.sv
// ----------------------------------------------------------------------------
// abm_char_mask
// Character mask: bit i low where pattern byte i equals the text byte and
// i lies inside the active pattern length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abm_char_mask
    import abm_pkg::*;
(
    input  t_pat_bytes        i_pat,
    input  logic [CHAR_W-1:0] i_char,
    input  logic [LEN_W-1:0]  i_len,
    output t_vec              o_mask
);

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            o_mask[i] = !((LEN_W'(i) < i_len) && (i_pat[i] == i_char));
        end
    end

endmodule

### rtl/abm_cascade.sv
// ----------------------------------------------------------------------------
// abm_cascade
// Shift-or update of the error-level vectors and match detection.
// Levels above the active error limit keep their value unless a line starts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abm_cascade
    import abm_pkg::*;
(
    input  t_vec_bank            i_vecs,
    input  logic                 i_line_start,
    input  t_vec                 i_mask,
    input  logic [ERR_W-1:0]     i_kerr,
    input  logic [LEN_IDX_W-1:0] i_len_m1,
    output t_vec_bank            o_vecs,
    output logic                 o_hit
);

    t_vec_bank base;
    t_vec      hit_vec;

    always_comb begin
        base = i_line_start ? '1 : i_vecs;
        o_vecs[0] = {base[0][PATTERN_MAX-2:0], 1'b0} | i_mask;
        for (int e = 1; e <= ERRORS_MAX; e++) begin
            if (ERR_W'(e) <= i_kerr) begin
                o_vecs[e] = base[e-1]
                          & {base[e-1][PATTERN_MAX-2:0], 1'b0}
                          & {o_vecs[e-1][PATTERN_MAX-2:0], 1'b0}
                          & ({base[e][PATTERN_MAX-2:0], 1'b0} | i_mask);
            end else begin
                o_vecs[e] = base[e];
            end
        end
    end

    assign hit_vec = o_vecs[i_kerr];
    assign o_hit   = !hit_vec[i_len_m1];

endmodule

### rtl/approximate_bitap_matcher_top.sv
// ----------------------------------------------------------------------------
// approximate_bitap_matcher_top
// Approximate string matcher, shift-or bitap with up to ERRORS_MAX edits.
//
// Input channel (i_in_valid / i_in_data / o_in_stall) carries one text byte
// and a line-start flag per transaction. Output channel (o_out_valid /
// o_out_data / i_out_stall) returns one result per byte: match_end and the
// saturating per-line match count.
// The accepted byte is held in the input register, and the result register
// loads from it once the output can advance. Throughput: one byte per cycle
// while the receiver does not stall; the whole error cascade and the counter
// update sit between the input register and the result register. When the
// receiver stalls, the held result stays; a byte is still taken into the
// input register only while it is empty; then o_in_stall rises.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data, pattern words 0 to 3,
// length, error limit. Write only while idle.
// Reset: pipeline empty, vectors all ones, count zero, pattern zero,
// length one, error limit zero. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "approximate_bitap_matcher_top_macros.svh"

module approximate_bitap_matcher_top
    import abm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_pat_bytes           r_pat;
    logic [LEN_W-1:0]     r_len;
    logic [ERR_W-1:0]     r_kerr;

    logic                 r_s1_valid;
    t_in_item             r_s1;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_vec_bank            r_vecs;
    logic [CNT_W-1:0]     r_count;

    t_vec_bank            n_vecs;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     cnt_base;
    logic                 out_adv;
    logic                 s1_fire;
    logic                 in_fire;
    logic                 hit;
    logic [LEN_W-1:0]     eff_len;
    logic [LEN_IDX_W-1:0] len_m1;
    logic [ERR_W-1:0]     eff_kerr;
    t_vec                 mask;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_len  <= LEN_W'(1);
            r_kerr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_0, CFG_PATTERN_1, CFG_PATTERN_2, CFG_PATTERN_3: begin
                    for (int p = 0; p < PATTERN_MAX; p++) begin
                        if ((p / 8 < PATTERN_WORDS) && (2'(p / 8) == i_cfg_index[1:0])) begin
                            r_pat[p] <= i_cfg_data[(p % 8) * 8 +: CHAR_W];
                        end
                    end
                end
                CFG_LENGTH:     r_len  <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_ERRORS: r_kerr <= i_cfg_data[ERR_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped configuration
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(PATTERN_MAX)) begin
            eff_len = LEN_W'(PATTERN_MAX);
        end else begin
            eff_len = r_len;
        end
        eff_kerr = (r_kerr > ERR_W'(ERRORS_MAX)) ? ERR_W'(ERRORS_MAX) : r_kerr;
    end

    assign len_m1 = LEN_IDX_W'(eff_len - LEN_W'(1));

    // Handshake
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_adv;
    assign o_in_stall = r_s1_valid && !out_adv;
    assign in_fire    = i_in_valid && !o_in_stall;

    abm_char_mask u_mask (
        .i_pat  (r_pat),
        .i_char (r_s1.text_char),
        .i_len  (eff_len),
        .o_mask (mask)
    );

    abm_cascade u_cascade (
        .i_vecs       (r_vecs),
        .i_line_start (r_s1.line_start),
        .i_mask       (mask),
        .i_kerr       (eff_kerr),
        .i_len_m1     (len_m1),
        .o_vecs       (n_vecs),
        .o_hit        (hit)
    );

    always_comb begin
        cnt_base = r_s1.line_start ? '0 : r_count;
        n_count  = (hit && (cnt_base != '1)) ? cnt_base + CNT_W'(1) : cnt_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vecs      <= '1;
            r_count     <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_vecs      <= n_vecs;
                r_count     <= n_count;
            end else if (out_adv) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in_data;
        end
        if (s1_fire) begin
            r_out.match_end    <= hit;
            r_out.line_matches <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ABM_ASSERT_SAME(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall && r_s1_valid)
    `ABM_ASSERT_NEXT(a_count_step, s1_fire && !r_s1.line_start && hit && (r_count != '1), r_count == $past(r_count) + CNT_W'(1))
    `ABM_ASSERT_NEXT(a_line_restart, s1_fire && r_s1.line_start, r_count == CNT_W'($past(hit)))
    `ABM_ASSERT_NEXT(a_result_count, s1_fire, o_out_valid && (o_out_data.line_matches == r_count))

endmodule
